[hdl/l_curve_corner_finder_top_assert.svh]
// Assertion macros for the L-curve corner finder.
// Expects clk and rst in the scope of every use.
`ifndef L_CURVE_CORNER_FINDER_TOP_ASSERT_SVH
`define L_CURVE_CORNER_FINDER_TOP_ASSERT_SVH

// same-cycle implication
`define LCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/lcc_pkg.sv]
// Shared widths, state types and the difference stencil of the corner finder.
// No dependencies.
`default_nettype none
package lcc_pkg;

  localparam int LOG_W      = 32;
  localparam int REG_W      = 32;
  localparam int HALF_WIN   = 4;
  localparam int WIN        = 2 * HALF_WIN;
  localparam int FRAC_BITS  = LOG_W - 8;
  localparam int FILL_W     = 4;
  localparam int S_W        = 40;
  localparam int T_W        = 46;
  localparam int N_W        = 80;
  localparam int Q_W        = 76;
  localparam int Q3_W       = 3 * Q_W;
  localparam int RHS_SH     = 2 * FRAC_BITS + 34;
  localparam int RHS_W      = 2 * N_W + RHS_SH;
  localparam int QUO_W      = 64;
  localparam int DV_W       = Q3_W + QUO_W;
  localparam int ROOT_W     = QUO_W / 2;
  localparam int CNT_W      = $clog2(QUO_W);
  localparam int MA_W       = 2 * Q_W;
  localparam int MB_W       = N_W;
  localparam int MP_W       = MA_W + MB_W;
  localparam int CURV_W     = 32;
  localparam int IN_DATA_W  = 2 * LOG_W + REG_W;
  localparam int OUT_DATA_W = CURV_W + 2 * REG_W;
  localparam int OUT_USER_W = 2;

  localparam logic [CURV_W-1:0] CURV_MAX = {1'b0, {(CURV_W-1){1'b1}}};
  localparam logic [CURV_W-1:0] CURV_MIN = {1'b1, {(CURV_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_SDIFF, ST_TDIFF, ST_M_P1, ST_M_P2, ST_M_SR, ST_M_SE,
    ST_M_Q2, ST_M_Q3, ST_M_N2, ST_ROOT, ST_FIN
  } seq_state_t;

  typedef enum logic [2:0] {
    R_IDLE, R_CHK, R_DIV, R_SQI, R_SQ, R_DONE
  } root_state_t;

  // five-point central difference times 12: a,b below centre, d,e above
  function automatic logic signed [T_W-1:0] fd5(input logic signed [T_W-1:0] a,
                                                input logic signed [T_W-1:0] b,
                                                input logic signed [T_W-1:0] d,
                                                input logic signed [T_W-1:0] e);
    logic signed [T_W-1:0] diff;
    diff = d - b;
    return (diff <<< 3) + a - e;
  endfunction

endpackage
`default_nettype wire

[hdl/lcc_mul.sv]
// Shift-and-add multiplier of unsigned magnitudes, one partial product a cycle.
// Depends on lcc_pkg.
`default_nettype none
module lcc_mul (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [lcc_pkg::MA_W-1:0] a,
  input  wire logic [lcc_pkg::MB_W-1:0] b,
  output logic                          busy,
  output logic                          done,
  output logic [lcc_pkg::MP_W-1:0]      product
);
  import lcc_pkg::*;

  logic            run;
  logic [MP_W-1:0] acc;
  logic [MP_W-1:0] ash;
  logic [MB_W-1:0] bsh;

  assign busy    = run;
  assign done    = run && (bsh == '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
      acc <= '0;
      ash <= MP_W'(a);
      bsh <= b;
    end else if (run) begin
      if (done) begin
        run <= 1'b0;
      end else begin
        if (bsh[0]) begin
          acc <= acc + ash;
        end
        ash <= ash << 1;
        bsh <= bsh >> 1;
      end
    end
  end
endmodule
`default_nettype wire

[hdl/lcc_root.sv]
// Restoring divider then digit-by-digit square root: floor(sqrt(floor(rhs / q3))).
// Depends on lcc_pkg.
`default_nettype none
module lcc_root (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [lcc_pkg::RHS_W-1:0] rhs,
  input  wire logic [lcc_pkg::Q3_W-1:0]  q3,
  output logic                           busy,
  output logic                           done,
  output logic [lcc_pkg::ROOT_W-1:0]     root
);
  import lcc_pkg::*;

  root_state_t      phase;
  logic [RHS_W-1:0] rem;
  logic [DV_W-1:0]  dv;
  logic [QUO_W-1:0] quo;
  logic [QUO_W-1:0] x;
  logic [QUO_W-1:0] res;
  logic [QUO_W-1:0] one;
  logic [QUO_W-1:0] trial;
  logic [CNT_W-1:0] cnt;
  logic             ge;

  assign ge    = DV_W'(rem) >= dv;
  assign trial = res + one;
  assign busy  = phase != R_IDLE;
  assign done  = phase == R_DONE;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= R_IDLE;
    end else begin
      case (phase)
        R_IDLE: begin
          if (start) begin
            rem   <= rhs;
            dv    <= {q3, {QUO_W{1'b0}}};
            phase <= R_CHK;
          end
        end
        R_CHK: begin
          if (ge) begin
            quo   <= '1;
            phase <= R_SQI;
          end else begin
            dv    <= dv >> 1;
            cnt   <= CNT_W'(QUO_W - 1);
            phase <= R_DIV;
          end
        end
        R_DIV: begin
          if (ge) begin
            rem <= rem - dv[RHS_W-1:0];
          end
          quo <= {quo[QUO_W-2:0], ge};
          dv  <= dv >> 1;
          if (cnt == '0) begin
            phase <= R_SQI;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        R_SQI: begin
          x     <= quo;
          res   <= '0;
          one   <= QUO_W'(1) << (QUO_W - 2);
          cnt   <= CNT_W'(ROOT_W - 1);
          phase <= R_SQ;
        end
        R_SQ: begin
          if (x >= trial) begin
            x   <= x - trial;
            res <= (res >> 1) + one;
          end else begin
            res <= res >> 1;
          end
          one <= one >> 2;
          if (cnt == '0) begin
            phase <= R_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        R_DONE: begin
          phase <= R_IDLE;
        end
        default: begin
          phase <= R_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/l_curve_corner_finder_top.sv]
// L-curve corner finder: nine-point window, curvature sequencer, best tracking.
// Depends on lcc_pkg, lcc_mul, lcc_root and l_curve_corner_finder_top_assert.svh.
//
//  channel | direction | tdata (low bit up)                        | tuser               | tlast
//  s_axis  | in        | log_residual, log_solution, reg_value     | point_valid         | scan_last
//  m_axis  | out       | curvature, centre_reg, peak_reg           | curvature_valid,    | result_last
//          |           |                                           | best_found          |
//
// One item at a time. A point with no curvature to compute goes from the difference steps
// straight to the final step; a computed point first runs the bit-serial multiplier for
// seven products and then the divide and square-root unit.
// Reset is synchronous; afterwards the block takes items at once, no clearing pass.
// A stalled m_axis holds the finished item in the final step until the output register frees.
`default_nettype none
`include "l_curve_corner_finder_top_assert.svh"
module l_curve_corner_finder_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [lcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // log_residual, log_solution, reg_value
  input  wire logic                           s_axis_tuser,  // point_valid
  input  wire logic                           s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [lcc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // curvature, centre_reg, peak_reg
  output logic [lcc_pkg::OUT_USER_W-1:0]      m_axis_tuser,  // curvature_valid, best_found
  output logic                                m_axis_tlast
);
  import lcc_pkg::*;

  seq_state_t state, state_next;

  logic signed [LOG_W-1:0] rwin [WIN];
  logic signed [LOG_W-1:0] ewin [WIN];
  logic [WIN-1:0]          vwin;
  logic [REG_W-1:0]        regd [HALF_WIN];
  logic [FILL_W-1:0]       fill;

  logic signed [LOG_W-1:0] cur_r, cur_e;
  logic [REG_W-1:0]        cur_reg;
  logic                    cur_v, cur_last;

  logic signed [T_W-1:0] xr [WIN+1];
  logic signed [T_W-1:0] xe [WIN+1];
  logic signed [T_W-1:0] sr_c [5];
  logic signed [T_W-1:0] se_c [5];
  logic signed [S_W-1:0] sr [5];
  logic signed [S_W-1:0] se [5];
  logic signed [T_W-1:0] tr, te;

  logic [S_W-1:0] sr_mag, se_mag;
  logic [T_W-1:0] tr_mag, te_mag;
  logic           p1_neg, p2_neg;
  logic [N_W-1:0] p1, p2;
  logic [Q_W-1:0] sr2, q;
  logic [MA_W-1:0] q2;
  logic [Q3_W-1:0] q3;
  logic [2*N_W-1:0] n2;
  logic signed [N_W+2:0] p1s, p2s, nval, nabs;
  logic [N_W-1:0] n_mag;
  logic           n_neg;

  logic [CURV_W-1:0] curv, curv_next, peak_curv;
  logic              cvalid;
  logic [REG_W-1:0]  peak_reg;
  logic              best_seen;

  logic              m_valid;
  logic [OUT_DATA_W-1:0] m_data;
  logic [OUT_USER_W-1:0] m_user;
  logic              m_last;

  logic              full, allv, produce, fin_go, accept, is_mul, upd, out_load;
  logic [REG_W-1:0]  creg, peak_reg_new;
  logic              best_seen_new;

  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic              mul_start, mul_busy, mul_done;
  logic [MP_W-1:0]   prod;
  logic              root_start, root_busy, root_done;
  logic [ROOT_W-1:0] root;

  assign full     = fill == FILL_W'(WIN);
  assign allv     = (&vwin) & cur_v;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign produce  = full || cur_last;
  assign fin_go   = !produce || !m_valid || m_axis_tready;
  assign out_load = (state == ST_FIN) && fin_go && produce;
  assign creg     = full ? regd[0] : '0;

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;
  assign m_axis_tuser  = m_user;
  assign m_axis_tlast  = m_last;

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      xr[i] = T_W'(rwin[i]);
      xe[i] = T_W'(ewin[i]);
    end
    xr[WIN] = T_W'(cur_r);
    xe[WIN] = T_W'(cur_e);
    for (int i = 0; i < 5; i++) begin
      sr_c[i] = fd5(xr[i], xr[i+1], xr[i+3], xr[i+4]);
      se_c[i] = fd5(xe[i], xe[i+1], xe[i+3], xe[i+4]);
    end
  end

  always_comb begin
    sr_mag = sr[2][S_W-1] ? $unsigned(-sr[2]) : $unsigned(sr[2]);
    se_mag = se[2][S_W-1] ? $unsigned(-se[2]) : $unsigned(se[2]);
    tr_mag = tr[T_W-1] ? $unsigned(-tr) : $unsigned(tr);
    te_mag = te[T_W-1] ? $unsigned(-te) : $unsigned(te);
    p1_neg = sr[2][S_W-1] ^ te[T_W-1];
    p2_neg = se[2][S_W-1] ^ tr[T_W-1];
    p1s    = p1_neg ? -$signed({3'b000, p1}) : $signed({3'b000, p1});
    p2s    = p2_neg ? -$signed({3'b000, p2}) : $signed({3'b000, p2});
    nval   = p1s - p2s;
    n_neg  = nval[N_W+2];
    nabs   = n_neg ? -nval : nval;
    n_mag  = nabs[N_W-1:0];
  end

  always_comb begin
    if (n_neg) begin
      curv_next = root[ROOT_W-1] ? CURV_MIN : CURV_W'(-root);
    end else begin
      curv_next = root[ROOT_W-1] ? CURV_MAX : CURV_W'(root);
    end
    upd           = cvalid && (!best_seen || ($signed(curv) > $signed(peak_curv)));
    peak_reg_new  = upd ? creg : peak_reg;
    best_seen_new = best_seen | upd;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_M_P1: begin
        mul_a = MA_W'(sr_mag);
        mul_b = MB_W'(te_mag);
      end
      ST_M_P2: begin
        mul_a = MA_W'(se_mag);
        mul_b = MB_W'(tr_mag);
      end
      ST_M_SR: begin
        mul_a = MA_W'(sr_mag);
        mul_b = MB_W'(sr_mag);
      end
      ST_M_SE: begin
        mul_a = MA_W'(se_mag);
        mul_b = MB_W'(se_mag);
      end
      ST_M_Q2: begin
        mul_a = MA_W'(q);
        mul_b = MB_W'(q);
      end
      ST_M_Q3: begin
        mul_a = q2;
        mul_b = MB_W'(q);
      end
      ST_M_N2: begin
        mul_a = MA_W'(n_mag);
        mul_b = MB_W'(n_mag);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = state == ST_IDLE;
    is_mul        = state inside {ST_M_P1, ST_M_P2, ST_M_SR, ST_M_SE, ST_M_Q2, ST_M_Q3,
                                  ST_M_N2};
    mul_start     = is_mul && !mul_busy;
    root_start    = (state == ST_ROOT) && !root_busy;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SDIFF;
        end
      end
      ST_SDIFF: begin
        state_next = ST_TDIFF;
      end
      ST_TDIFF: begin
        if (full && allv && (sr[2] != '0 || se[2] != '0)) begin
          state_next = ST_M_P1;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_M_P1: if (mul_done) state_next = ST_M_P2;
      ST_M_P2: if (mul_done) state_next = ST_M_SR;
      ST_M_SR: if (mul_done) state_next = ST_M_SE;
      ST_M_SE: if (mul_done) state_next = ST_M_Q2;
      ST_M_Q2: if (mul_done) state_next = ST_M_Q3;
      ST_M_Q3: if (mul_done) state_next = ST_M_N2;
      ST_M_N2: if (mul_done) state_next = ST_ROOT;
      ST_ROOT: if (root_done) state_next = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      vwin      <= '0;
      peak_curv <= CURV_MIN;
      peak_reg  <= '0;
      best_seen <= 1'b0;
      cvalid    <= 1'b0;
      m_valid   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !out_load) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_r    <= s_axis_tdata[LOG_W-1:0];
            cur_e    <= s_axis_tdata[2*LOG_W-1:LOG_W];
            cur_reg  <= s_axis_tdata[IN_DATA_W-1:2*LOG_W];
            cur_v    <= s_axis_tuser;
            cur_last <= s_axis_tlast;
            cvalid   <= 1'b0;
          end
        end
        ST_SDIFF: begin
          for (int i = 0; i < 5; i++) begin
            sr[i] <= sr_c[i][S_W-1:0];
            se[i] <= se_c[i][S_W-1:0];
          end
        end
        ST_TDIFF: begin
          tr <= fd5(T_W'(sr[0]), T_W'(sr[1]), T_W'(sr[3]), T_W'(sr[4]));
          te <= fd5(T_W'(se[0]), T_W'(se[1]), T_W'(se[3]), T_W'(se[4]));
        end
        ST_M_P1: if (mul_done) p1 <= prod[N_W-1:0];
        ST_M_P2: if (mul_done) p2 <= prod[N_W-1:0];
        ST_M_SR: if (mul_done) sr2 <= prod[Q_W-1:0];
        ST_M_SE: if (mul_done) q <= sr2 + prod[Q_W-1:0];
        ST_M_Q2: if (mul_done) q2 <= prod[MA_W-1:0];
        ST_M_Q3: if (mul_done) q3 <= prod[Q3_W-1:0];
        ST_M_N2: if (mul_done) n2 <= prod[2*N_W-1:0];
        ST_ROOT: begin
          if (root_done) begin
            curv   <= curv_next;
            cvalid <= 1'b1;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            if (produce) begin
              m_valid <= 1'b1;
              m_data  <= {peak_reg_new, creg, cvalid ? curv : CURV_W'(0)};
              m_user  <= {best_seen_new, cvalid};
              m_last  <= cur_last;
            end
            if (cur_last) begin
              fill      <= '0;
              vwin      <= '0;
              peak_curv <= CURV_MIN;
              peak_reg  <= '0;
              best_seen <= 1'b0;
            end else begin
              for (int i = 0; i < WIN - 1; i++) begin
                rwin[i] <= rwin[i+1];
                ewin[i] <= ewin[i+1];
              end
              rwin[WIN-1] <= cur_r;
              ewin[WIN-1] <= cur_e;
              vwin        <= {cur_v, vwin[WIN-1:1]};
              for (int i = 0; i < HALF_WIN - 1; i++) begin
                regd[i] <= regd[i+1];
              end
              regd[HALF_WIN-1] <= cur_reg;
              if (!full) begin
                fill <= fill + 1'b1;
              end
              if (upd) begin
                peak_curv <= curv;
              end
              peak_reg  <= peak_reg_new;
              best_seen <= best_seen_new;
            end
          end
        end
        default: begin
          cvalid <= cvalid;
        end
      endcase
    end
  end

  lcc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (prod)
  );

  lcc_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .rhs   ({n2, {RHS_SH{1'b0}}}),
    .q3    (q3),
    .busy  (root_busy),
    .done  (root_done),
    .root  (root)
  );

  `LCC_ASSERT_NEXT(a_single_item, accept, !s_axis_tready, "second transfer while busy")
  `LCC_ASSERT_NOW(a_root_owned, root_busy, state == ST_ROOT, "root unit busy outside its step")
  `LCC_ASSERT_NOW(a_mul_owned, mul_busy, is_mul, "multiplier busy outside a product step")
  `LCC_ASSERT_NOW(a_best_clear, $fell(best_seen), $past(state == ST_FIN && cur_last), "early clear")
endmodule
`default_nettype wire

[bench/tb_l_curve_corner_finder_top.sv]
// Self-checking bench for the L-curve corner finder: drives scans of L-curve points on
// s_axis and checks every m_axis transfer against a bit-exact curvature predictor.
// Depends on lcc_pkg and l_curve_corner_finder_top.
`timescale 1ns / 1ps

module tb_l_curve_corner_finder_top;
  import lcc_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 700;

  typedef struct {
    logic signed [31:0] res;
    logic signed [31:0] sol;
    logic [31:0]        rval;
    logic               pv;
    logic               last;
  } point_t;

  typedef struct {
    logic signed [31:0] curv;
    logic               cvalid;
    logic [31:0]        creg;
    logic [31:0]        breg;
    logic               bfound;
    logic               rlast;
  } corner_t;

  class corner_scoreboard;
    corner_t            pending[$];
    int                 errors;
    logic signed [31:0] res_win[WIN];
    logic signed [31:0] sol_win[WIN];
    logic               ok_win[WIN];
    logic [31:0]        reg_win[HALF_WIN];
    int                 fill;
    logic signed [31:0] peak_curv;
    logic [31:0]        peak_reg;
    logic               seen;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      for (int i = 0; i < WIN; i++) begin
        res_win[i] = 0;
        sol_win[i] = 0;
        ok_win[i] = 0;
      end
      for (int i = 0; i < HALF_WIN; i++) reg_win[i] = 0;
      fill = 0;
      peak_curv = 32'sh80000000;
      peak_reg = 0;
      seen = 0;
    endfunction

    function longint fd(longint am2, longint am1, longint ap1, longint ap2);
      return -ap2 + 8 * ap1 - 8 * am1 + am2;
    endfunction

    function logic signed [31:0] curvature(longint sr, longint se, longint tr, longint te);
      logic signed [127:0] n;
      logic [127:0]        nm;
      logic [127:0]        q;
      logic [319:0]        q3;
      logic [319:0]        rhs;
      logic [319:0]        kk;
      logic [63:0]         lo;
      logic [63:0]         hi;
      logic [63:0]         mid;
      logic                neg;
      n = 128'(sr) * 128'(te) - 128'(se) * 128'(tr);
      neg = n < 0;
      nm = neg ? -n : n;
      q = 128'(sr) * 128'(sr) + 128'(se) * 128'(se);
      q3 = 320'(q) * 320'(q);
      q3 = q3 * 320'(q);
      rhs = (320'(nm) * 320'(nm)) << RHS_SH;
      lo = 0;
      hi = 64'd1 << 31;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        kk = 320'(mid * mid);
        if (kk * q3 <= rhs) lo = mid;
        else hi = mid - 1;
      end
      if (neg) return -lo[31:0];
      return (lo > 64'h7fffffff) ? 32'sh7fffffff : lo[31:0];
    endfunction

    function void note_point(point_t p);
      longint  xr[WIN+1];
      longint  xe[WIN+1];
      longint  sr[WIN+1];
      longint  se[WIN+1];
      logic    allv;
      logic    full;
      corner_t c;
      full = fill >= WIN;
      c.curv = 0;
      c.cvalid = 0;
      c.creg = 0;
      if (full) begin
        allv = p.pv;
        for (int i = 0; i < WIN; i++) begin
          xr[i] = res_win[i];
          xe[i] = sol_win[i];
          if (!ok_win[i]) allv = 0;
        end
        xr[WIN] = p.res;
        xe[WIN] = p.sol;
        c.creg = reg_win[0];
        if (allv) begin
          for (int i = HALF_WIN - 2; i <= HALF_WIN + 2; i++) begin
            sr[i] = fd(xr[i-2], xr[i-1], xr[i+1], xr[i+2]);
            se[i] = fd(xe[i-2], xe[i-1], xe[i+1], xe[i+2]);
          end
          if (sr[HALF_WIN] != 0 || se[HALF_WIN] != 0) begin
            c.curv = curvature(sr[HALF_WIN], se[HALF_WIN],
                               fd(sr[2], sr[3], sr[5], sr[6]),
                               fd(se[2], se[3], se[5], se[6]));
            c.cvalid = 1;
            if (!seen || c.curv > peak_curv) begin
              peak_curv = c.curv;
              peak_reg = c.creg;
              seen = 1;
            end
          end
        end
      end
      for (int i = 0; i < WIN - 1; i++) begin
        res_win[i] = res_win[i+1];
        sol_win[i] = sol_win[i+1];
        ok_win[i] = ok_win[i+1];
      end
      res_win[WIN-1] = p.res;
      sol_win[WIN-1] = p.sol;
      ok_win[WIN-1] = p.pv;
      for (int i = 0; i < HALF_WIN - 1; i++) reg_win[i] = reg_win[i+1];
      reg_win[HALF_WIN-1] = p.rval;
      if (fill < WIN) fill++;
      if (full || p.last) begin
        c.breg = peak_reg;
        c.bfound = seen;
        c.rlast = p.last;
        pending.insert(pending.size(), c);
      end
      if (p.last) clear();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_corner(corner_t r);
      corner_t e;
      if (pending.size() == 0) begin
        report("unexpected transfer", r.curv, 0);
        return;
      end
      e = pending.pop_front();
      if (r.curv !== e.curv) report("curvature", r.curv, e.curv);
      if (r.cvalid !== e.cvalid) report("curvature_valid", r.cvalid, e.cvalid);
      if (r.creg !== e.creg) report("centre_reg", r.creg, e.creg);
      if (r.breg !== e.breg) report("peak_reg", r.breg, e.breg);
      if (r.bfound !== e.bfound) report("best_found", r.bfound, e.bfound);
      if (r.rlast !== e.rlast) report("result_last", r.rlast, e.rlast);
    endtask
  endclass

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // log_residual, log_solution, reg_value
  logic                  s_axis_tuser = 0;   // point_valid
  logic                  s_axis_tlast = 0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // curvature, centre_reg, peak_reg
  logic [OUT_USER_W-1:0] m_axis_tuser;       // curvature_valid, best_found
  logic                  m_axis_tlast;

  corner_scoreboard sb = new();
  logic             calm = 0;
  int               cycles = 0;
  int               sent = 0;

  l_curve_corner_finder_top dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= rst ? 1'b0 : (calm || $urandom_range(0, 99) >= 19);
  end

  always @(posedge clk) begin
    point_t p;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      p.res = s_axis_tdata[31:0];
      p.sol = s_axis_tdata[63:32];
      p.rval = s_axis_tdata[95:64];
      p.pv = s_axis_tuser;
      p.last = s_axis_tlast;
      sb.note_point(p);
    end
  end

  always @(posedge clk) begin
    corner_t r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      r.curv = m_axis_tdata[31:0];
      r.creg = m_axis_tdata[63:32];
      r.breg = m_axis_tdata[95:64];
      r.cvalid = m_axis_tuser[0];
      r.bfound = m_axis_tuser[1];
      r.rlast = m_axis_tlast;
      sb.check_corner(r);
    end
  end

  task send_point(logic [31:0] res, logic [31:0] sol, logic [31:0] rval, logic pv, logic last);
    if (!calm && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {rval, sol, res};
    s_axis_tuser <= pv;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task send_scan(int len, int mode);
    logic [31:0] r0, e0, dr, de;
    logic [31:0] res, sol;
    logic        pv;
    r0 = $urandom;
    e0 = $urandom;
    dr = $urandom_range(0, 1 << 22) - (1 << 21);
    de = $urandom_range(0, 1 << 22) - (1 << 21);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: begin
          res = $urandom;
          sol = $urandom;
        end
        1: begin
          res = r0 + i * dr + $urandom_range(0, 4095);
          sol = e0 + i * de + (i * i) * $urandom_range(0, 255);
        end
        default: begin
          res = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
          sol = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        end
      endcase
      pv = $urandom_range(0, 29) != 0;
      send_point(res, sol, $urandom, pv, i == len - 1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // scans cut short before the window fills
    send_point(32'h7fffffff, 32'h80000000, 32'hffffffff, 1, 1);
    for (int i = 0; i < 3; i++) send_point($urandom, $urandom, $urandom, 1, i == 2);
    // straight line: zero curvature
    for (int i = 0; i < 9; i++)
      send_point(i << 24, 32'h80000000 + (i << 20), i, 1, i == 8);
    // flat curve: zero denominator
    for (int i = 0; i < 9; i++) send_point(32'h12345678, 32'h9abcdef0, i, 1, i == 8);
    // extremes of the logs
    for (int i = 0; i < 9; i++)
      send_point(i[0] ? 32'h7fffffff : 32'h80000000, i[1] ? 32'h80000000 : 32'h7fffffff,
                 ~i, 1, i == 8);
    while (sent < 1100) begin
      calm = (sent > 400 && sent < 600);
      if ($urandom_range(0, 9) == 0) send_scan($urandom_range(1, 8), $urandom_range(0, 2));
      else send_scan($urandom_range(9, 20), $urandom_range(0, 9) < 6 ? 1 :
                     $urandom_range(0, 9) < 8 ? 0 : 2);
    end
    s_axis_tvalid <= 0;
    calm = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) sb.report("results left over", sb.pending.size(), 0);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/lcc_pkg.sv
hdl/lcc_mul.sv
hdl/lcc_root.sv
hdl/l_curve_corner_finder_top.sv
bench/tb_l_curve_corner_finder_top.sv
